>>> rtl/core/assert_macros.svh
// Assertion helper macros for the point projection RTL.
// Expect i_clk and i_rst_n in the scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock, off while reset is low.
`define RTPP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Same check, written with an explicit implication.
`define RTPP_ASSERT_IMP(label, ante, cons, msg) \
    `RTPP_ASSERT(label, (ante) |-> (cons), msg)

`endif

>>> rtl/core/rtpp_pkg.sv
// Shared types, constants and saturating helpers for the point projection.
// No dependencies.
package rtpp_pkg;

    localparam logic signed [63:0] Q_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] Q_MIN  = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] Q_ONE  = 64'sh0000_0001_0000_0000;
    localparam logic        [31:0] PIX_NEG_ONE = 32'hFFFF_0000;
    localparam logic        [31:0] FOCAL_RESET = 32'h0001_0000;
    localparam int unsigned        QMUL_LAT    = 4;
    localparam int unsigned        DIV_STEPS   = 64;

    typedef enum logic [2:0] {
        REG_FOCAL_X   = 3'd0,
        REG_FOCAL_Y   = 3'd1,
        REG_CENTER_X  = 3'd2,
        REG_CENTER_Y  = 3'd3,
        REG_RADIAL_K1 = 3'd4,
        REG_RADIAL_K2 = 3'd5,
        REG_RADIAL_K3 = 3'd6,
        REG_TAN_PAIR  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } t_point_in;

    typedef struct packed {
        logic signed [31:0] pixel_u;
        logic signed [31:0] pixel_v;
        logic               behind_camera;
    } t_pixel_out;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if ((a[63] == b[63]) && (s[63] != a[63])) begin
            sat_add = a[63] ? Q_MIN : Q_MAX;
        end else begin
            sat_add = s;
        end
    endfunction

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        if (!v[63] && (|v[62:31])) begin
            sat32 = 32'h7FFF_FFFF;
        end else if (v[63] && !(&v[62:31])) begin
            sat32 = 32'h8000_0000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

    // Q31.32 coefficient from a Q4.28 register.
    function automatic logic signed [63:0] q28_to_q32(input logic [31:0] c);
        q28_to_q32 = {{28{c[31]}}, c, 4'b0000};
    endfunction

endpackage

>>> rtl/core/rtpp_qmul.sv
// Pipelined Q31.32 multiply: (a*b)>>32, magnitude truncated, saturated.
// Four register stages; depends on rtpp_pkg.
module rtpp_qmul import rtpp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic signed [63:0] o_p
);

    logic        r_neg1, r_neg2, r_neg3;
    logic [63:0] r_ma, r_mb;
    logic [63:0] r_ll, r_lh, r_hl, r_hh;
    logic [63:0] r_r;
    logic        r_ov;
    logic signed [63:0] r_p;
    logic [33:0] n_mid;
    logic [63:0] n_hi;
    logic        n_sat;

    // stage 1: sign and magnitudes
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg1 <= i_a[63] ^ i_b[63];
            r_ma   <= i_a[63] ? (~i_a + 64'd1) : i_a;
            r_mb   <= i_b[63] ? (~i_b + 64'd1) : i_b;
        end
    end

    // stage 2: 32x32 partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg2 <= r_neg1;
            r_ll   <= r_ma[31:0]  * r_mb[31:0];
            r_lh   <= r_ma[31:0]  * r_mb[63:32];
            r_hl   <= r_ma[63:32] * r_mb[31:0];
            r_hh   <= r_ma[63:32] * r_mb[63:32];
        end
    end

    // stage 3: gather the middle 64 bits, flag overflow of the top word
    always_comb begin
        n_mid = {2'b00, r_ll[63:32]} + {2'b00, r_lh[31:0]} + {2'b00, r_hl[31:0]};
        n_hi  = r_hh + {32'd0, r_lh[63:32]} + {32'd0, r_hl[63:32]} + {62'd0, n_mid[33:32]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg3 <= r_neg2;
            r_r    <= {n_hi[31:0], n_mid[31:0]};
            r_ov   <= |n_hi[63:32];
        end
    end

    // stage 4: saturate and restore sign
    assign n_sat = r_ov || (r_neg3 ? (r_r > 64'h8000_0000_0000_0000) : r_r[63]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (n_sat) begin
                r_p <= r_neg3 ? Q_MIN : Q_MAX;
            end else begin
                r_p <= r_neg3 ? signed'(~r_r + 64'd1) : signed'(r_r);
            end
        end
    end

    assign o_p = r_p;

endmodule

>>> rtl/core/radtan_point_projection.sv
// Radial-tangential point projection, top level. Uses rtpp_pkg, rtpp_qmul.
// Datapath: a 64-step divider, sign fixup, a multiply/add chain and an
// output register.
// Throughput: one item per clock; one global enable freezes the whole pipe
// while the output item waits. Synchronous active-low reset clears valids
// and loads register defaults (focal 1.0, all else zero).
module radtan_point_projection import rtpp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_point_in   i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_pixel_out  o_out_item,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

`include "assert_macros.svh"

    localparam int unsigned T0   = DIV_STEPS + 1;   // xn/yn register slot
    localparam int unsigned LAST = T0 + 31;         // output register slot

    // configuration registers
    logic [31:0] r_focal_x, r_focal_y, r_center_x, r_center_y;
    logic [31:0] r_k1, r_k2, r_k3;
    logic [63:0] r_tan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x  <= FOCAL_RESET;
            r_focal_y  <= FOCAL_RESET;
            r_center_x <= '0;
            r_center_y <= '0;
            r_k1       <= '0;
            r_k2       <= '0;
            r_k3       <= '0;
            r_tan      <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_FOCAL_X:   r_focal_x  <= i_cfg_data[31:0];
                REG_FOCAL_Y:   r_focal_y  <= i_cfg_data[31:0];
                REG_CENTER_X:  r_center_x <= i_cfg_data[31:0];
                REG_CENTER_Y:  r_center_y <= i_cfg_data[31:0];
                REG_RADIAL_K1: r_k1       <= i_cfg_data[31:0];
                REG_RADIAL_K2: r_k2       <= i_cfg_data[31:0];
                REG_RADIAL_K3: r_k3       <= i_cfg_data[31:0];
                REG_TAN_PAIR:  r_tan      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The user must change config only while idle; the block does not enforce it. Stages read it directly.
    logic signed [63:0] w_k1, w_k2, w_k3, w_p1, w_p2;
    logic signed [63:0] w_fx, w_fy, w_cx, w_cy;
    assign w_k1 = q28_to_q32(r_k1);
    assign w_k2 = q28_to_q32(r_k2);
    assign w_k3 = q28_to_q32(r_k3);
    assign w_p1 = q28_to_q32(r_tan[63:32]);
    assign w_p2 = q28_to_q32(r_tan[31:0]);
    assign w_fx = {32'd0, r_focal_x};
    assign w_fy = {32'd0, r_focal_y};
    assign w_cx = {{32{r_center_x[31]}}, r_center_x};
    assign w_cy = {{32{r_center_y[31]}}, r_center_y};

    // pipeline control: valid and behind flags ride alongside the data
    logic             w_en;
    logic [LAST:0]    r_vld;
    logic [LAST-1:0]  r_bhd;

    assign w_en        = !r_vld[LAST] || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_vld[LAST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAST-1:0], i_in_valid};
        end
    end

    // entry slot: magnitudes, signs, divisor
    logic        w_behind;
    logic [31:0] w_mag_x, w_mag_y;
    assign w_behind = i_in_item.point_z[31] || (i_in_item.point_z == 32'sd0);
    assign w_mag_x  = i_in_item.point_x[31] ? (~i_in_item.point_x + 32'd1)
                                            : i_in_item.point_x;
    assign w_mag_y  = i_in_item.point_y[31] ? (~i_in_item.point_y + 32'd1)
                                            : i_in_item.point_y;

    logic [30:0] r_rem_x [0:DIV_STEPS];
    logic [30:0] r_rem_y [0:DIV_STEPS];
    logic [63:0] r_acc_x [0:DIV_STEPS];
    logic [63:0] r_acc_y [0:DIV_STEPS];
    logic [30:0] r_dv    [0:DIV_STEPS];
    logic        r_sx    [0:DIV_STEPS];
    logic        r_sy    [0:DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bhd      <= {r_bhd[LAST-2:0], w_behind};
            r_rem_x[0] <= '0;
            r_rem_y[0] <= '0;
            r_acc_x[0] <= {w_mag_x, 32'd0};
            r_acc_y[0] <= {w_mag_y, 32'd0};
            r_sx[0]    <= i_in_item.point_x[31];
            r_sy[0]    <= i_in_item.point_y[31];
            // behind items get a harmless divisor, result is overridden
            r_dv[0]    <= w_behind ? 31'd1 : i_in_item.point_z[30:0];
        end
    end

    // restoring divider, one quotient bit per stage; the accumulator
    // shifts dividend bits out the top and quotient bits in the bottom
    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
        logic [31:0] w_tx, w_ty;
        logic        w_gx, w_gy;
        assign w_tx = {r_rem_x[s], r_acc_x[s][63]};
        assign w_ty = {r_rem_y[s], r_acc_y[s][63]};
        assign w_gx = w_tx >= {1'b0, r_dv[s]};
        assign w_gy = w_ty >= {1'b0, r_dv[s]};
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rem_x[s+1] <= w_gx ? 31'(w_tx - {1'b0, r_dv[s]}) : w_tx[30:0];
                r_rem_y[s+1] <= w_gy ? 31'(w_ty - {1'b0, r_dv[s]}) : w_ty[30:0];
                r_acc_x[s+1] <= {r_acc_x[s][62:0], w_gx};
                r_acc_y[s+1] <= {r_acc_y[s][62:0], w_gy};
                r_dv[s+1]    <= r_dv[s];
                r_sx[s+1]    <= r_sx[s];
                r_sy[s+1]    <= r_sy[s];
            end
        end
    end

    // t0: signed normalized coordinates, truncated toward zero
    logic signed [63:0] r_xn, r_yn;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xn <= r_sx[DIV_STEPS] ? signed'(~r_acc_x[DIV_STEPS] + 64'd1)
                                    : signed'(r_acc_x[DIV_STEPS]);
            r_yn <= r_sy[DIV_STEPS] ? signed'(~r_acc_y[DIV_STEPS] + 64'd1)
                                    : signed'(r_acc_y[DIV_STEPS]);
        end
    end

    // t4: squares and cross term
    logic signed [63:0] m_xx, m_yy, m_xy;
    rtpp_qmul u_mul_xx (.i_clk, .i_en(w_en), .i_a(r_xn), .i_b(r_xn), .o_p(m_xx));
    rtpp_qmul u_mul_yy (.i_clk, .i_en(w_en), .i_a(r_yn), .i_b(r_yn), .o_p(m_yy));
    rtpp_qmul u_mul_xy (.i_clk, .i_en(w_en), .i_a(r_xn), .i_b(r_yn), .o_p(m_xy));

    // t5: r2 and doubled terms; t6: tangential sums
    logic signed [63:0] r_r2, r_xx2, r_yy2, r_xy2;
    logic signed [63:0] r_ax, r_ay, r_xy2d;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r2   <= sat_add(m_xx, m_yy);
            r_xx2  <= sat_add(m_xx, m_xx);
            r_yy2  <= sat_add(m_yy, m_yy);
            r_xy2  <= sat_add(m_xy, m_xy);
            r_ax   <= sat_add(r_r2, r_xx2);
            r_ay   <= sat_add(r_r2, r_yy2);
            r_xy2d <= r_xy2;
        end
    end

    // delay lines: r2 (t6..t15), xn/yn (t1..t20), tx/ty (t12..t24)
    logic signed [63:0] r_r2_dl [0:9];
    logic signed [63:0] r_xn_dl [0:19];
    logic signed [63:0] r_yn_dl [0:19];
    logic signed [63:0] r_tx_dl [0:12];
    logic signed [63:0] r_ty_dl [0:12];
    logic signed [63:0] r_tx, r_ty;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r2_dl[0] <= r_r2;
            r_xn_dl[0] <= r_xn;
            r_yn_dl[0] <= r_yn;
            r_tx_dl[0] <= r_tx;
            r_ty_dl[0] <= r_ty;
            for (int i = 1; i < 10; i++) r_r2_dl[i] <= r_r2_dl[i-1];
            for (int i = 1; i < 20; i++) begin
                r_xn_dl[i] <= r_xn_dl[i-1];
                r_yn_dl[i] <= r_yn_dl[i-1];
            end
            for (int i = 1; i < 13; i++) begin
                r_tx_dl[i] <= r_tx_dl[i-1];
                r_ty_dl[i] <= r_ty_dl[i-1];
            end
        end
    end

    // radial polynomial, Horner form: k3 -> k2 -> k1 -> 1
    logic signed [63:0] m_k3, m_p1r, m_p2r;
    logic signed [63:0] r_poly1, r_poly2, r_radial;
    rtpp_qmul u_mul_k3 (.i_clk, .i_en(w_en), .i_a(r_r2), .i_b(w_k3), .o_p(m_k3));
    rtpp_qmul u_mul_h2 (.i_clk, .i_en(w_en), .i_a(r_r2_dl[4]), .i_b(r_poly1),
                        .o_p(m_p1r));
    rtpp_qmul u_mul_h1 (.i_clk, .i_en(w_en), .i_a(r_r2_dl[9]), .i_b(r_poly2),
                        .o_p(m_p2r));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_poly1  <= sat_add(w_k2, m_k3);     // t10
            r_poly2  <= sat_add(w_k1, m_p1r);    // t15
            r_radial <= sat_add(Q_ONE, m_p2r);   // t20
        end
    end

    // tangential terms, started at t6, summed at t11
    logic signed [63:0] m_t1x, m_t2x, m_t1y, m_t2y;
    rtpp_qmul u_mul_t1x (.i_clk, .i_en(w_en), .i_a(w_p1), .i_b(r_xy2d), .o_p(m_t1x));
    rtpp_qmul u_mul_t2x (.i_clk, .i_en(w_en), .i_a(w_p2), .i_b(r_ax),   .o_p(m_t2x));
    rtpp_qmul u_mul_t1y (.i_clk, .i_en(w_en), .i_a(w_p1), .i_b(r_ay),   .o_p(m_t1y));
    rtpp_qmul u_mul_t2y (.i_clk, .i_en(w_en), .i_a(w_p2), .i_b(r_xy2d), .o_p(m_t2y));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tx <= sat_add(m_t1x, m_t2x);
            r_ty <= sat_add(m_t1y, m_t2y);
        end
    end

    // t24: scaled coordinate; t25: distorted coordinate
    logic signed [63:0] m_rx, m_ry, r_xd, r_yd;
    rtpp_qmul u_mul_rx (.i_clk, .i_en(w_en), .i_a(r_xn_dl[19]), .i_b(r_radial),
                        .o_p(m_rx));
    rtpp_qmul u_mul_ry (.i_clk, .i_en(w_en), .i_a(r_yn_dl[19]), .i_b(r_radial),
                        .o_p(m_ry));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xd <= sat_add(m_rx, r_tx_dl[12]);
            r_yd <= sat_add(m_ry, r_ty_dl[12]);
        end
    end

    // t29: focal scale (Q16.16 result); t30: principal point
    logic signed [63:0] m_fu, m_fv, r_u, r_v;
    rtpp_qmul u_mul_fu (.i_clk, .i_en(w_en), .i_a(w_fx), .i_b(r_xd), .o_p(m_fu));
    rtpp_qmul u_mul_fv (.i_clk, .i_en(w_en), .i_a(w_fy), .i_b(r_yd), .o_p(m_fv));

    t_pixel_out r_out;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_u <= sat_add(m_fu, w_cx);
            r_v <= sat_add(m_fv, w_cy);
            // t31: clamp to 32 bits, or the behind-camera marker
            if (r_bhd[LAST-1]) begin
                r_out.pixel_u       <= PIX_NEG_ONE;
                r_out.pixel_v       <= PIX_NEG_ONE;
                r_out.behind_camera <= 1'b1;
            end else begin
                r_out.pixel_u       <= sat32(r_u);
                r_out.pixel_v       <= sat32(r_v);
                r_out.behind_camera <= 1'b0;
            end
        end
    end

    assign o_out_item = r_out;

    // checks
    `RTPP_ASSERT_IMP(a_behind_marker, o_out_valid && o_out_item.behind_camera,
        o_out_item.pixel_u == PIX_NEG_ONE && o_out_item.pixel_v == PIX_NEG_ONE,
        "behind item without -1.0 marker")
    `RTPP_ASSERT_IMP(a_div_rem, r_vld[DIV_STEPS],
        r_rem_x[DIV_STEPS] < r_dv[DIV_STEPS] && r_rem_y[DIV_STEPS] < r_dv[DIV_STEPS],
        "divider remainder not below divisor")
    `RTPP_ASSERT(a_stall_freeze, !o_in_ready |=> $stable(r_vld),
        "pipeline moved while stalled")

endmodule

>>> dv/radtan_point_projection_tb.sv
// Self-checking testbench for radtan_point_projection: a lens projection predictor
// checks every pixel item under random sender gaps and receiver stalls.
// Depends on rtpp_pkg (port types, register indexes) and the RTL of the block.
module radtan_point_projection_tb;
    import rtpp_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;   // idle cycles with work pending
    localparam int DRAIN_CYCLES   = 120;    // cycles waited after the final drain

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_point_in   i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_pixel_out  o_out_item;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    // Lens settings as the block should hold them.
    logic [31:0]        lens_fx, lens_fy;
    logic signed [31:0] lens_cx, lens_cy, lens_k1, lens_k2, lens_k3;
    logic [63:0]        lens_tan;

    t_pixel_out pixel_q[$];
    int         err_cnt = 0;
    int         burst_left = 0;
    int         long_stall = 0;
    bit         long_stall_go = 1'b0;
    int         idle_cycles = 0;

    radtan_point_projection i_dut (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Predictor: Q31.32 fixed point, truncating products, saturation
    // ---------------------------------------------------------------
    function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
        return s[63:0];
    endfunction

    // Exact product, shifted down by 32 with the magnitude truncated.
    function automatic logic signed [63:0] qprod(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        logic signed [127:0] full;
        logic [127:0]        mag;
        logic [127:0]        sh;
        logic                neg;
        full = a * b;
        neg  = full[127];
        mag  = neg ? -full : full;
        sh   = mag >> 32;
        if (neg) begin
            if (sh > 128'h8000_0000_0000_0000) return Q_MIN;
            return -sh[63:0];
        end
        if (sh > 128'h7FFF_FFFF_FFFF_FFFF) return Q_MAX;
        return sh[63:0];
    endfunction

    // Q4.28 coefficient widened to Q31.32.
    function automatic logic signed [63:0] coef(input logic [31:0] c);
        logic signed [63:0] t;
        t = $signed(c);
        return t * 16;
    endfunction

    function automatic logic [31:0] clip32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic t_pixel_out project_point(input t_point_in p);
        t_pixel_out         r;
        logic signed [63:0] num_x, num_y, den, xn, yn, xx, yy, xy, r2, poly, radial;
        logic signed [63:0] k1, k2, k3, p1, p2, tx, ty, xd, yd, u, v, fx, fy, cx, cy;
        if (p.point_z <= 0) begin
            r.pixel_u = PIX_NEG_ONE;
            r.pixel_v = PIX_NEG_ONE;
            r.behind_camera = 1'b1;
            return r;
        end
        k1 = coef(lens_k1);
        k2 = coef(lens_k2);
        k3 = coef(lens_k3);
        p1 = coef(lens_tan[63:32]);
        p2 = coef(lens_tan[31:0]);
        num_x = $signed({p.point_x, 32'h0});
        num_y = $signed({p.point_y, 32'h0});
        den   = p.point_z;
        xn = num_x / den;
        yn = num_y / den;
        xx = qprod(xn, xn);
        yy = qprod(yn, yn);
        xy = qprod(xn, yn);
        r2 = sadd(xx, yy);
        poly   = sadd(k2, qprod(r2, k3));
        poly   = sadd(k1, qprod(r2, poly));
        radial = sadd(Q_ONE, qprod(r2, poly));
        tx = sadd(qprod(p1, sadd(xy, xy)), qprod(p2, sadd(r2, sadd(xx, xx))));
        ty = sadd(qprod(p1, sadd(r2, sadd(yy, yy))), qprod(p2, sadd(xy, xy)));
        xd = sadd(qprod(xn, radial), tx);
        yd = sadd(qprod(yn, radial), ty);
        fx = {32'h0, lens_fx};
        fy = {32'h0, lens_fy};
        cx = lens_cx;
        cy = lens_cy;
        u = sadd(qprod(fx, xd), cx);
        v = sadd(qprod(fy, yd), cy);
        r.pixel_u = clip32(u);
        r.pixel_v = clip32(v);
        r.behind_camera = 1'b0;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Monitors: expectation on input accept, check on output accept
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) pixel_q.push_back(project_point(i_in_item));
    end

    always @(posedge i_clk) begin
        t_pixel_out exp_px;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pixel_q.size() == 0) begin
                err_cnt++;
                $display("%0t unexpected pixel item: expected none, got %h", $time, o_out_item);
            end else begin
                exp_px = pixel_q.pop_front();
                if (o_out_item.pixel_u !== exp_px.pixel_u) begin
                    err_cnt++;
                    $display("%0t pixel_u mismatch: expected %h, got %h",
                             $time, exp_px.pixel_u, o_out_item.pixel_u);
                end
                if (o_out_item.pixel_v !== exp_px.pixel_v) begin
                    err_cnt++;
                    $display("%0t pixel_v mismatch: expected %h, got %h",
                             $time, exp_px.pixel_v, o_out_item.pixel_v);
                end
                if (o_out_item.behind_camera !== exp_px.behind_camera) begin
                    err_cnt++;
                    $display("%0t behind_camera mismatch: expected %b, got %b",
                             $time, exp_px.behind_camera, o_out_item.behind_camera);
                end
            end
        end
    end

    // Receiver: stall mode is re-drawn at random from three modes; a long hold-off overrides it.
    always @(posedge i_clk) begin
        int mode;
        if (long_stall_go) begin
            long_stall = 400;
            long_stall_go = 1'b0;
        end
        if (($time / 12) % 64 == 0) mode = $urandom_range(0, 2);
        if (long_stall > 0) begin
            long_stall--;
            i_out_ready <= 1'b0;
        end else begin
            case (mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= ($urandom_range(0, 3) != 0);
                default: i_out_ready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    // Watchdog: no progress while work is pending.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (!i_in_valid && pixel_q.size() == 0)) begin
            idle_cycles = 0;
        end else if (++idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    // Send one point; the sender may idle between bursts of random length.
    task automatic send_point(input t_point_in p);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_item  <= p;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pixel_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [63:0] d);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_FOCAL_X:   lens_fx = d[31:0];
            REG_FOCAL_Y:   lens_fy = d[31:0];
            REG_CENTER_X:  lens_cx = d[31:0];
            REG_CENTER_Y:  lens_cy = d[31:0];
            REG_RADIAL_K1: lens_k1 = d[31:0];
            REG_RADIAL_K2: lens_k2 = d[31:0];
            REG_RADIAL_K3: lens_k3 = d[31:0];
            default:       lens_tan = d;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_lens(input logic [31:0] fx, input logic [31:0] fy,
                            input logic [31:0] cx, input logic [31:0] cy,
                            input logic [31:0] k1, input logic [31:0] k2,
                            input logic [31:0] k3, input logic [63:0] tan);
        wait_drained();
        write_reg(REG_FOCAL_X, {32'h0, fx});
        write_reg(REG_FOCAL_Y, {32'h0, fy});
        write_reg(REG_CENTER_X, {32'h0, cx});
        write_reg(REG_CENTER_Y, {32'h0, cy});
        write_reg(REG_RADIAL_K1, {32'h0, k1});
        write_reg(REG_RADIAL_K2, {32'h0, k2});
        write_reg(REG_RADIAL_K3, {32'h0, k3});
        write_reg(REG_TAN_PAIR, tan);
    endtask

    function automatic logic [31:0] small_coef(input int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    // Mostly points in front of a plausible camera; some raw noise and
    // some points behind the camera.
    function automatic t_point_in rand_point();
        t_point_in p;
        int        sel, z;
        sel = $urandom_range(0, 99);
        if (sel < 12) begin
            p.point_x = $urandom;
            p.point_y = $urandom;
            p.point_z = $urandom;
        end else if (sel < 18) begin
            p.point_x = $urandom;
            p.point_y = $urandom;
            p.point_z = {1'b1, 31'($urandom)};
        end else begin
            z = $urandom_range(32'h0000_1000, 32'h00C8_0000);
            p.point_z = z;
            p.point_x = int'($urandom_range(0, 4 * z)) - 2 * z;
            p.point_y = int'($urandom_range(0, 4 * z)) - 2 * z;
        end
        return p;
    endfunction

    task automatic send_random(input int n);
        repeat (n) send_point(rand_point());
    endtask

    function automatic t_point_in pt(input logic [31:0] x, input logic [31:0] y,
                                     input logic [31:0] z);
        t_point_in p;
        p.point_x = x;
        p.point_y = y;
        p.point_z = z;
        return p;
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Reset defaults: unit focal, no center, no distortion.
    task automatic test_reset_defaults();
        send_point(pt(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000));
        send_point(pt(32'h0, 32'h0, 32'h0));                  // depth zero
        send_point(pt(32'h1234_5678, 32'h0, 32'hFFFF_FFFF));  // depth -1 lsb
        send_point(pt(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
        send_point(pt(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001)); // tiny depth
        send_point(pt(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF)); // far depth
        send_point(pt(32'h0000_8000, 32'h0000_4000, 32'h0001_0000));
    endtask

    // Extreme register values with extreme and ordinary points.
    task automatic test_extreme_lens();
        set_lens(32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 64'h8000_0000_7FFF_FFFF);
        send_point(pt(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        send_point(pt(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001));
        send_point(pt(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
        send_point(pt(32'h0, 32'h0, 32'h0001_0000));
        send_point(pt(32'h0, 32'h0, 32'h8000_0000));
        set_lens(32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                 64'h7FFF_FFFF_8000_0000);
        send_point(pt(32'h0000_4000, 32'hFFFF_C000, 32'h0001_0000));
        send_point(pt(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001));
        send_point(pt(32'h0001_0000, 32'h0002_0000, 32'h7FFF_FFFF));
        send_point(pt(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0003));
        send_point(pt(32'h0, 32'h0, 32'hFFFF_FFFF));
    endtask

    // Plausible lenses with random points; one phase with raw random registers.
    task automatic test_random_lenses();
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5) begin
                set_lens($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, {$urandom, $urandom});
            end else begin
                set_lens($urandom_range(32'h0064_0000, 32'h07D0_0000),
                         $urandom_range(32'h0064_0000, 32'h07D0_0000),
                         $urandom_range(0, 32'h03E8_0000), $urandom_range(0, 32'h03E8_0000),
                         small_coef(1 << 27), small_coef(1 << 25), small_coef(1 << 23),
                         {small_coef(1 << 22), small_coef(1 << 22)});
            end
            send_random(250);
        end
    endtask

    // Long receiver hold-off fills the pipe and stalls the input; then the
    // sender pauses until the block has delivered everything.
    task automatic test_backpressure();
        set_lens(32'h01F4_0000, 32'h01F4_0000, 32'h0140_0000, 32'h00F0_0000,
                 small_coef(1 << 26), small_coef(1 << 24), small_coef(1 << 22),
                 {small_coef(1 << 21), small_coef(1 << 21)});
        long_stall_go = 1'b1;
        send_random(200);
        wait_drained();
        send_random(100);
    endtask

    initial begin
        lens_fx = FOCAL_RESET;
        lens_fy = FOCAL_RESET;
        lens_cx = '0;
        lens_cy = '0;
        lens_k1 = '0;
        lens_k2 = '0;
        lens_k3 = '0;
        lens_tan = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_extreme_lens();
        test_random_lenses();
        test_backpressure();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
